### rtl/assert_macros.svh
// assertion macros shared by the rtl files
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// clocked assertion, disabled while reset is asserted
`define TSAR_ASSERT(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// condition in one cycle requires the property in the next, disabled in reset
`define TSAR_ASSERT_NEXT(label, cond, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (prop)) \
        else $error(msg);

`endif

### rtl/tsar_pkg.sv
// package with types, constants and helper functions of the syn/ack responder
`timescale 1ns / 1ps
package tsar_pkg;

    localparam int REPLY_WORDS = 37;
    localparam int ADDR_W = 6;
    localparam int CAP_WORDS = 24;
    localparam logic [ADDR_W-1:0] LAST_IDX = 6'd36;
    localparam logic [3:0] SUM_LAST = 4'd12;
    localparam logic [15:0] ETH_IPV4 = 16'h0800;
    localparam logic [7:0] PROTO_TCP = 8'd6;
    localparam logic [15:0] SYN_ACK_BITS = 16'h0012;
    localparam logic [15:0] TTL_HI = 16'hFF00;
    localparam logic [31:0] LFSR_MASK = 32'h8020_0003;
    localparam logic [15:0] PORT_RESET = 16'd19420;
    localparam logic [31:0] SEED_RESET = 32'd1;
    localparam logic REG_LISTEN_PORT = 1'b0;
    localparam logic REG_SEQ_SEED = 1'b1;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SUM,
        ST_RD,
        ST_LOAD,
        ST_OUT
    } tsar_state_t;

    typedef struct packed {
        logic              in_ready;
        logic              sum_en;
        logic [3:0]        sum_step;
        logic              rd_en;
        logic [ADDR_W-1:0] word_idx;
        logic              load;
        logic              out_valid;
    } tsar_cmd_t;

    typedef struct packed {
        logic frame_done;
    } tsar_stat_t;

    function automatic logic [15:0] oc_add(input logic [15:0] a, input logic [15:0] b);
        logic [16:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[15:0] + {15'd0, s[16]};
    endfunction

endpackage

### rtl/tsar_channels.sv
// stream interfaces for received frame items and reply items
`timescale 1ns / 1ps
interface tsar_frame_if;
    logic        valid;
    logic        ready;
    logic [15:0] data_word;
    logic        last_word;
    logic        half_word;
    modport source (output valid, output data_word, output last_word, output half_word,
                    input ready);
    modport sink (input valid, input data_word, input last_word, input half_word,
                  output ready);
endinterface

interface tsar_reply_if;
    logic        valid;
    logic        ready;
    logic [15:0] reply_word;
    logic        reply_last;
    modport source (output valid, output reply_word, output reply_last, input ready);
    modport sink (input valid, input reply_word, input reply_last, output ready);
endinterface

### rtl/tsar_ram.sv
// generic ram with one write port and one registered read port
`timescale 1ns / 1ps
module tsar_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 37
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem_reg [0:DEPTH-1];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;
endmodule

### rtl/tsar_ctrl.sv
// controller: capture, checksum steps and reply sequencing
`timescale 1ns / 1ps
`include "assert_macros.svh"
module tsar_ctrl import tsar_pkg::*; (
    input  logic       clk,
    input  logic       rst_n,
    input  tsar_stat_t stat,
    input  logic       out_ready,
    output tsar_cmd_t  cmd
);
    tsar_state_t       state_reg, state_next;
    logic [3:0]        step_reg, step_next;
    logic [ADDR_W-1:0] word_reg, word_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            step_reg  <= '0;
            word_reg  <= '0;
        end
        else
        begin
            state_reg <= state_next;
            step_reg  <= step_next;
            word_reg  <= word_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        step_next  = step_reg;
        word_next  = word_reg;
        case (state_reg)
            ST_IDLE:
            begin
                step_next = '0;
                word_next = '0;
                if (stat.frame_done)
                begin
                    state_next = ST_SUM;
                end
            end
            ST_SUM:
            begin
                if (step_reg == SUM_LAST)
                begin
                    state_next = ST_RD;
                end
                else
                begin
                    step_next = step_reg + 4'd1;
                end
            end
            ST_RD:
            begin
                state_next = ST_LOAD;
            end
            ST_LOAD:
            begin
                state_next = ST_OUT;
            end
            ST_OUT:
            begin
                if (out_ready)
                begin
                    if (word_reg == LAST_IDX)
                    begin
                        state_next = ST_IDLE;
                    end
                    else
                    begin
                        word_next  = word_reg + 6'd1;
                        state_next = ST_RD;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        cmd           = '0;
        cmd.sum_step  = step_reg;
        cmd.word_idx  = word_reg;
        case (state_reg)
            ST_IDLE: cmd.in_ready  = 1'b1;
            ST_SUM:  cmd.sum_en    = 1'b1;
            ST_RD:   cmd.rd_en     = 1'b1;
            ST_LOAD: cmd.load      = 1'b1;
            ST_OUT:  cmd.out_valid = 1'b1;
            default: cmd.in_ready  = 1'b0;
        endcase
    end

    `TSAR_ASSERT(a_done_only_idle, stat.frame_done |-> state_reg == ST_IDLE, "done outside idle")
    `TSAR_ASSERT_NEXT(a_last_to_idle, state_reg == ST_OUT && out_ready && word_reg == LAST_IDX, state_reg == ST_IDLE, "reply did not end")
    `TSAR_ASSERT(a_one_side, !(cmd.in_ready && cmd.out_valid), "input and reply both active")
endmodule

### rtl/tsar_datapath.sv
// datapath: header store, checksums, lfsr and reply word assembly
`timescale 1ns / 1ps
`include "assert_macros.svh"
module tsar_datapath import tsar_pkg::*; #(
    parameter int MAX_FRAME_BYTES = 1500
) (
    input  logic        clk,
    input  logic        rst_n,
    input  tsar_cmd_t   cmd,
    output tsar_stat_t  stat,
    input  logic        in_valid,
    input  logic [15:0] data_word,
    input  logic        last_word,
    input  logic        half_word,
    input  logic [15:0] listen_port,
    input  logic        seed_load,
    input  logic [31:0] seed_value,
    output logic [15:0] reply_word,
    output logic        reply_last
);
    localparam int WORD_CAP = MAX_FRAME_BYTES / 2;
    localparam int CNT_W = $clog2(WORD_CAP + 1);
    localparam int LEN_W = $clog2(MAX_FRAME_BYTES + 1);
    localparam int CMP_W = (CNT_W + 1 > LEN_W ? CNT_W + 1 : LEN_W) + 1;
    localparam logic [CNT_W-1:0] CAP_CNT = CNT_W'(WORD_CAP);

    logic [CNT_W-1:0] count_reg;
    logic [15:0]      seg_reg;
    logic [15:0]      cap_reg [0:CAP_WORDS-1];
    logic [LEN_W-1:0] len_reg;
    logic [31:0]      lfsr_reg, seq_reg, ack_reg;
    logic [15:0]      ip_sum_reg, tcp_sum_reg;
    logic [15:0]      reply_word_reg;
    logic             reply_last_reg;

    logic             in_fire, took, seg_add, too_short, match;
    logic [15:0]      w, seg_next, ram_rdata, tcp_term, ip_term;
    logic [CNT_W:0]   cnt_after;
    logic [CNT_W:0]   off;
    logic [ADDR_W-1:0] raddr;

    function automatic logic [LEN_W-1:0] seg_len(input logic [15:0] tot);
        logic [15:0] l;
        l = tot - 16'd20;
        if (tot < 16'd20)
        begin
            return '0;
        end
        else if ({1'b0, l} > 17'(MAX_FRAME_BYTES))
        begin
            return LEN_W'(MAX_FRAME_BYTES);
        end
        else
        begin
            return l[LEN_W-1:0];
        end
    endfunction

    function automatic logic [15:0] seg_take(input logic [15:0] v,
                                             input logic [CMP_W-1:0] o,
                                             input logic [LEN_W-1:0] len);
        logic [CMP_W-1:0] lx;
        lx = CMP_W'(len);
        if (o >= lx)
        begin
            return '0;
        end
        else if (o + CMP_W'(1) >= lx)
        begin
            return {v[15:8], 8'd0};
        end
        else
        begin
            return v;
        end
    endfunction

    assign in_fire = in_valid && cmd.in_ready;
    assign w       = (last_word && half_word) ? {data_word[15:8], 8'd0} : data_word;
    assign took    = count_reg < CAP_CNT;
    assign off     = {count_reg, 1'b0} - (CNT_W + 1)'(34);
    assign seg_add = took && (count_reg >= CNT_W'(37) || count_reg == CNT_W'(24)
                     || (count_reg >= CNT_W'(26) && count_reg <= CNT_W'(36)));
    assign seg_next = seg_add ? oc_add(seg_reg, seg_take(w, CMP_W'(off), len_reg)) : seg_reg;
    assign cnt_after = took ? {1'b0, count_reg} + (CNT_W + 1)'(1) : {1'b0, count_reg};
    assign too_short = cnt_after < (CNT_W + 1)'(REPLY_WORDS)
                       || (cnt_after == (CNT_W + 1)'(REPLY_WORDS) && took && half_word);
    assign match = cap_reg[6] == ETH_IPV4 && cap_reg[11][7:0] == PROTO_TCP
                   && cap_reg[18] == listen_port && cap_reg[23][1];
    assign stat.frame_done = in_fire && last_word && !too_short && match;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
            seg_reg   <= '0;
            lfsr_reg  <= SEED_RESET;
        end
        else
        begin
            if (in_fire)
            begin
                if (last_word)
                begin
                    count_reg <= '0;
                    seg_reg   <= '0;
                end
                else
                begin
                    seg_reg <= seg_next;
                    if (took)
                    begin
                        count_reg <= count_reg + CNT_W'(1);
                    end
                end
            end
            if (seed_load)
            begin
                lfsr_reg <= (seed_value == '0) ? 32'd1 : seed_value;
            end
            else if (stat.frame_done)
            begin
                lfsr_reg <= (lfsr_reg >> 1) ^ (lfsr_reg[0] ? LFSR_MASK : 32'd0);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_fire && took && count_reg < CNT_W'(CAP_WORDS))
        begin
            cap_reg[count_reg[4:0]] <= w;
        end
        if (in_fire && took && count_reg == CNT_W'(8))
        begin
            len_reg <= seg_len(w);
        end
        if (stat.frame_done)
        begin
            seq_reg     <= lfsr_reg;
            ack_reg     <= {cap_reg[19], cap_reg[20]} + 32'd1;
            tcp_sum_reg <= seg_next;
            ip_sum_reg  <= '0;
        end
        else if (cmd.sum_en)
        begin
            tcp_sum_reg <= oc_add(tcp_sum_reg, tcp_term);
            ip_sum_reg  <= oc_add(ip_sum_reg, ip_term);
        end
        if (cmd.load)
        begin
            reply_last_reg <= cmd.word_idx == LAST_IDX;
            case (cmd.word_idx)
                6'd11:   reply_word_reg <= TTL_HI | {8'd0, cap_reg[11][7:0]};
                6'd12:   reply_word_reg <= ~ip_sum_reg;
                6'd13:   reply_word_reg <= cap_reg[15];
                6'd14:   reply_word_reg <= cap_reg[16];
                6'd15:   reply_word_reg <= cap_reg[13];
                6'd16:   reply_word_reg <= cap_reg[14];
                6'd17:   reply_word_reg <= cap_reg[18];
                6'd18:   reply_word_reg <= cap_reg[17];
                6'd19:   reply_word_reg <= seq_reg[31:16];
                6'd20:   reply_word_reg <= seq_reg[15:0];
                6'd21:   reply_word_reg <= ack_reg[31:16];
                6'd22:   reply_word_reg <= ack_reg[15:0];
                6'd23:   reply_word_reg <= cap_reg[23] | SYN_ACK_BITS;
                6'd25:   reply_word_reg <= ~tcp_sum_reg;
                default: reply_word_reg <= ram_rdata;
            endcase
        end
    end

    always_comb
    begin
        case (cmd.sum_step)
            4'd0:    tcp_term = cap_reg[15];
            4'd1:    tcp_term = cap_reg[16];
            4'd2:    tcp_term = cap_reg[13];
            4'd3:    tcp_term = cap_reg[14];
            4'd4:    tcp_term = {8'd0, cap_reg[11][7:0]};
            4'd5:    tcp_term = cap_reg[8] - 16'd20;
            4'd6:    tcp_term = seg_take(cap_reg[18], CMP_W'(0), len_reg);
            4'd7:    tcp_term = seg_take(cap_reg[17], CMP_W'(2), len_reg);
            4'd8:    tcp_term = seg_take(seq_reg[31:16], CMP_W'(4), len_reg);
            4'd9:    tcp_term = seg_take(seq_reg[15:0], CMP_W'(6), len_reg);
            4'd10:   tcp_term = seg_take(ack_reg[31:16], CMP_W'(8), len_reg);
            4'd11:   tcp_term = seg_take(ack_reg[15:0], CMP_W'(10), len_reg);
            4'd12:   tcp_term = seg_take(cap_reg[23] | SYN_ACK_BITS, CMP_W'(12), len_reg);
            default: tcp_term = '0;
        endcase
        case (cmd.sum_step)
            4'd0:    ip_term = cap_reg[7];
            4'd1:    ip_term = cap_reg[8];
            4'd2:    ip_term = cap_reg[9];
            4'd3:    ip_term = cap_reg[10];
            4'd4:    ip_term = TTL_HI | {8'd0, cap_reg[11][7:0]};
            4'd5:    ip_term = cap_reg[15];
            4'd6:    ip_term = cap_reg[16];
            4'd7:    ip_term = cap_reg[13];
            4'd8:    ip_term = cap_reg[14];
            default: ip_term = '0;
        endcase
        if (cmd.word_idx < 6'd3)
        begin
            raddr = cmd.word_idx + 6'd3;
        end
        else if (cmd.word_idx < 6'd6)
        begin
            raddr = cmd.word_idx - 6'd3;
        end
        else
        begin
            raddr = cmd.word_idx;
        end
    end

    tsar_ram #(
        .WIDTH (16),
        .DEPTH (REPLY_WORDS)
    ) u_header_store (
        .clk   (clk),
        .we    (in_fire && took && count_reg < CNT_W'(REPLY_WORDS)),
        .waddr (count_reg[ADDR_W-1:0]),
        .wdata (w),
        .re    (cmd.rd_en),
        .raddr (raddr),
        .rdata (ram_rdata)
    );

    assign reply_word = reply_word_reg;
    assign reply_last = reply_last_reg;

    `TSAR_ASSERT(a_lfsr_nonzero, lfsr_reg != 32'd0, "lfsr reached zero")
    `TSAR_ASSERT(a_count_cap, count_reg <= CAP_CNT, "word count past cap")
    `TSAR_ASSERT(a_load_idx, !cmd.load || cmd.word_idx <= LAST_IDX, "reply index out of range")
endmodule

### rtl/tcp_syn_ack_responder_top.sv
// top level of the tcp syn/ack responder with apb configuration port
//
// in_ch takes a received ethernet frame as 16-bit big-endian items, one per
// cycle while ready is high; last_word ends the frame, half_word marks a
// final item that carries only its upper byte.
// an ipv4/tcp syn to listen_port is answered on out_ch with a 74-byte reply
// of 37 items, reply_last on the final one; other frames give nothing.
// after the last frame item the block computes both checksums in its sum steps, then
// emits the reply items one after another (header store read, load, hold for each).
// in_ch is not ready from the last item of a valid frame until the reply ends.
// a stalled receiver holds the current reply item in the output register.
// reset clears the control state and loads the sequence lfsr with 1;
// writing seq_seed reloads the lfsr (a zero loads 1).
// registers: listen_port at 0x0, seq_seed at 0x4; pready is always high.
`timescale 1ns / 1ps
module tcp_syn_ack_responder_top import tsar_pkg::*; #(
    parameter int MAX_FRAME_BYTES = 1500
) (
    input  logic         clk,
    input  logic         rst_n,
    tsar_frame_if.sink   in_ch,
    tsar_reply_if.source out_ch,
    input  logic         psel,
    input  logic         penable,
    input  logic         pwrite,
    input  logic [2:0]   paddr,
    input  logic [31:0]  pwdata,
    output logic [31:0]  prdata,
    output logic         pready
);
    tsar_cmd_t   cmd;
    tsar_stat_t  stat;
    logic [15:0] listen_port_reg;
    logic [31:0] seq_seed_reg;
    logic        cfg_write;

    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            listen_port_reg <= PORT_RESET;
            seq_seed_reg    <= SEED_RESET;
        end
        else if (cfg_write)
        begin
            if (paddr[2] == REG_LISTEN_PORT)
            begin
                listen_port_reg <= pwdata[15:0];
            end
            else
            begin
                seq_seed_reg <= pwdata;
            end
        end
    end

    assign prdata = (paddr[2] == REG_SEQ_SEED) ? seq_seed_reg : {16'd0, listen_port_reg};

    tsar_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .stat      (stat),
        .out_ready (out_ch.ready),
        .cmd       (cmd)
    );

    tsar_datapath #(
        .MAX_FRAME_BYTES (MAX_FRAME_BYTES)
    ) u_datapath (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd),
        .stat        (stat),
        .in_valid    (in_ch.valid),
        .data_word   (in_ch.data_word),
        .last_word   (in_ch.last_word),
        .half_word   (in_ch.half_word),
        .listen_port (listen_port_reg),
        .seed_load   (cfg_write && paddr[2] == REG_SEQ_SEED),
        .seed_value  (pwdata),
        .reply_word  (out_ch.reply_word),
        .reply_last  (out_ch.reply_last)
    );

    assign in_ch.ready  = cmd.in_ready;
    assign out_ch.valid = cmd.out_valid;
endmodule

### test/tcp_syn_ack_responder_top_test.sv
// testbench of the tcp syn/ack responder: directed frames against a built-in predictor
`timescale 1ns / 1ps
module tcp_syn_ack_responder_top_test import tsar_pkg::*;;

    localparam int WORD_CAP = 750;
    localparam int HDR_WORDS = 37;
    localparam int SETTLE_CYCLES = 200;

    typedef struct {
        logic [15:0] word;
        logic        last;
    } reply_item_t;

    logic        clk;
    logic        rst_n;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [2:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    tsar_frame_if in_if();
    tsar_reply_if out_if();

    tcp_syn_ack_responder_top dut (
        .clk(clk),
        .rst_n(rst_n),
        .in_ch(in_if),
        .out_ch(out_if),
        .psel(psel),
        .penable(penable),
        .pwrite(pwrite),
        .paddr(paddr),
        .pwdata(pwdata),
        .prdata(prdata),
        .pready(pready)
    );

    // predictor state
    logic [15:0] hdr_words [HDR_WORDS];
    int          rx_count;
    logic [15:0] seg_sum;
    logic [15:0] port_cfg;
    logic [31:0] seq_state;

    reply_item_t reply_q [$];
    logic [15:0] frm [$];
    int          errors;
    bit          no_idle;

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial
    begin
        #5ms;
        $display("FAILURE");
        $finish;
    end

    function automatic logic [15:0] ones_add(input logic [15:0] a, input logic [15:0] b);
        logic [16:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[15:0] + {15'd0, s[16]};
    endfunction

    function automatic int segment_bytes();
        int l;
        if (hdr_words[8] < 16'd20)
            return 0;
        l = int'(hdr_words[8]) - 20;
        return (l > 1500) ? 1500 : l;
    endfunction

    function automatic logic [15:0] seg_part(input logic [15:0] w, input int off, input int len);
        if (off >= len)
            return 16'h0000;
        if (off + 1 >= len)
            return {w[15:8], 8'h00};
        return w;
    endfunction

    task automatic predict_reply(input logic [15:0] w_in, input bit last, input bit half);
        logic [15:0] w;
        logic [15:0] r [HDR_WORDS];
        logic [15:0] ssum;
        logic [15:0] sum;
        logic [31:0] seq;
        logic [31:0] ack;
        reply_item_t it;
        int idx;
        int bytes;
        int len;
        bit took;
        w = (last && half) ? {w_in[15:8], 8'h00} : w_in;
        idx = rx_count;
        took = 0;
        if (idx < WORD_CAP)
        begin
            if (idx < HDR_WORDS)
                hdr_words[idx] = w;
            else
                seg_sum = ones_add(seg_sum, seg_part(w, 2 * idx - 34, segment_bytes()));
            rx_count = idx + 1;
            took = 1;
        end
        if (!last)
            return;
        bytes = 2 * rx_count - ((took && half) ? 1 : 0);
        ssum = seg_sum;
        rx_count = 0;
        seg_sum = 16'h0000;
        if (bytes < 2 * HDR_WORDS)
            return;
        if (hdr_words[6] != ETH_IPV4 || hdr_words[11][7:0] != PROTO_TCP ||
            hdr_words[18] != port_cfg || !hdr_words[23][1])
            return;
        for (int i = 0; i < HDR_WORDS; i++)
            r[i] = hdr_words[i];
        for (int i = 0; i < 3; i++)
        begin
            r[i] = hdr_words[3 + i];
            r[3 + i] = hdr_words[i];
        end
        r[11] = TTL_HI | {8'h00, hdr_words[11][7:0]};
        r[13] = hdr_words[15];
        r[14] = hdr_words[16];
        r[15] = hdr_words[13];
        r[16] = hdr_words[14];
        r[12] = 16'h0000;
        sum = 16'h0000;
        for (int i = 7; i <= 16; i++)
            sum = ones_add(sum, r[i]);
        r[12] = ~sum;
        r[17] = hdr_words[18];
        r[18] = hdr_words[17];
        seq = seq_state;
        seq_state = (seq_state >> 1) ^ (seq_state[0] ? LFSR_MASK : 32'h0);
        ack = {hdr_words[19], hdr_words[20]} + 32'd1;
        r[19] = seq[31:16];
        r[20] = seq[15:0];
        r[21] = ack[31:16];
        r[22] = ack[15:0];
        r[23] = hdr_words[23] | SYN_ACK_BITS;
        r[25] = 16'h0000;
        len = segment_bytes();
        sum = 16'h0000;
        for (int i = 13; i <= 16; i++)
            sum = ones_add(sum, r[i]);
        sum = ones_add(sum, {8'h00, r[11][7:0]});
        sum = ones_add(sum, hdr_words[8] - 16'd20);
        for (int i = 17; i < HDR_WORDS; i++)
            sum = ones_add(sum, seg_part(r[i], 2 * (i - 17), len));
        sum = ones_add(sum, ssum);
        r[25] = ~sum;
        for (int i = 0; i < HDR_WORDS; i++)
        begin
            it.word = r[i];
            it.last = (i == HDR_WORDS - 1);
            reply_q.push_back(it);
        end
    endtask

    task automatic send_item(input logic [15:0] w, input bit last, input bit half);
        @(negedge clk);
        while (!no_idle && $urandom_range(0, 99) < 28)
        begin
            in_if.valid = 1'b0;
            in_if.data_word = 16'($urandom);
            in_if.last_word = 1'($urandom);
            in_if.half_word = 1'($urandom);
            @(negedge clk);
        end
        in_if.valid = 1'b1;
        in_if.data_word = w;
        in_if.last_word = last;
        in_if.half_word = half;
        @(posedge clk);
        while (!in_if.ready)
            @(posedge clk);
        predict_reply(w, last, half);
    endtask

    always @(negedge clk)
        out_if.ready <= (no_idle || $urandom_range(0, 99) >= 28);

    always @(posedge clk)
    begin
        if (rst_n && out_if.valid && out_if.ready)
        begin
            if (reply_q.size() == 0)
            begin
                $display("%0t: unexpected reply item, actual word %h last %b", $time,
                         out_if.reply_word, out_if.reply_last);
                errors++;
            end
            else
            begin
                if (out_if.reply_word !== reply_q[0].word || out_if.reply_last !== reply_q[0].last)
                begin
                    $display("%0t: reply mismatch, expected word %h last %b, actual word %h last %b",
                             $time, reply_q[0].word, reply_q[0].last,
                             out_if.reply_word, out_if.reply_last);
                    errors++;
                end
                void'(reply_q.pop_front());
            end
        end
    end

    task automatic wait_idle();
        while (reply_q.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(input logic addr_sel, input logic [31:0] value);
        wait_idle();
        @(negedge clk);
        psel = 1'b1;
        penable = 1'b0;
        pwrite = 1'b1;
        paddr = {addr_sel, 2'b00};
        pwdata = value;
        @(negedge clk);
        penable = 1'b1;
        @(negedge clk);
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        if (addr_sel == REG_LISTEN_PORT)
            port_cfg = value[15:0];
        else
            seq_state = (value != 32'h0) ? value : 32'h1;
    endtask

    // fill: 0 all zeros, 1 all ones, else random
    task automatic make_frame(input int nwords, input logic [15:0] etype, input logic [7:0] proto,
                              input logic [15:0] dport, input bit syn, input logic [15:0] totlen,
                              input int fill);
        frm.delete();
        for (int i = 0; i < nwords; i++)
            frm.push_back(fill == 0 ? 16'h0000 : fill == 1 ? 16'hFFFF : 16'($urandom));
        if (nwords > 23)
        begin
            frm[6] = etype;
            frm[8] = totlen;
            frm[11][7:0] = proto;
            frm[18] = dport;
            frm[23][1] = syn;
        end
    endtask

    task automatic send_frame(input bit half_end);
        for (int i = 0; i < frm.size(); i++)
        begin
            if (i == frm.size() - 1)
                send_item(frm[i], 1'b1, half_end);
            else
                send_item(frm[i], 1'b0, 1'($urandom));
        end
        @(negedge clk);
        in_if.valid = 1'b0;
    endtask

    task automatic send_syn(input int payload, input int fill);
        make_frame(HDR_WORDS + (payload + 1) / 2, ETH_IPV4, PROTO_TCP, port_cfg, 1'b1,
                   16'(60 + payload), fill);
        send_frame(payload % 2 == 1);
    endtask

    task automatic test_basic_syn();
        // odd payload with a half last item, no idling on either side
        no_idle = 1;
        send_syn(1, 2);
        no_idle = 0;
    endtask

    task automatic test_rejected_frames();
        make_frame(4, ETH_IPV4, PROTO_TCP, port_cfg, 1'b1, 16'd60, 2);
        send_frame(0);
        make_frame(HDR_WORDS, ETH_IPV4, PROTO_TCP, port_cfg ^ 16'h0001, 1'b1, 16'd60, 2);
        send_frame(0);
    endtask

    task automatic test_register_extremes();
        write_reg(REG_LISTEN_PORT, 32'hFFFF);
        write_reg(REG_SEQ_SEED, 32'h0);
        // short totlen with an all-ones header
        make_frame(HDR_WORDS, ETH_IPV4, PROTO_TCP, port_cfg, 1'b1, 16'd10, 1);
        send_frame(0);
    endtask

    initial
    begin
        rst_n = 1'b0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        in_if.valid = 1'b0;
        in_if.data_word = '0;
        in_if.last_word = 1'b0;
        in_if.half_word = 1'b0;
        errors = 0;
        no_idle = 0;
        rx_count = 0;
        seg_sum = 16'h0000;
        port_cfg = PORT_RESET;
        seq_state = SEED_RESET;
        for (int i = 0; i < HDR_WORDS; i++)
            hdr_words[i] = 16'h0000;
        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        test_basic_syn();
        test_rejected_frames();
        test_register_extremes();

        wait_idle();
        if (errors == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule
